@@ rtl/lav_pkg.sv @@
// Shared types, constants and arithmetic helpers for the look-at view matrix block.
package lav_pkg;

	localparam int QW        = 32;
	localparam int MW        = 61;
	localparam int SW        = 31;
	localparam int SHW       = 6;
	localparam int EW        = 24;
	localparam int DDW       = 64;
	localparam int NW        = 49;
	localparam int RT_STEPS  = 31;
	localparam int DV_STEPS  = 18;
	localparam int SCALE_MSB = 29;
	localparam int FRAC      = 16;

	typedef logic signed [QW-1:0]    q_t;
	typedef logic [MW-1:0]           mag_t;
	typedef logic signed [SW-1:0]    sc_t;
	typedef logic signed [2*SW-1:0]  pr_t;
	typedef logic signed [EW-1:0]    e_t;
	typedef logic signed [2*EW-1:0]  ep_t;
	typedef logic signed [EW+QW-1:0] dp_t;
	typedef logic signed [DDW-1:0]   w_t;
	typedef logic [SHW-1:0]          sh_t;
	typedef logic [1:0]              col_t;

	localparam q_t   Q_ONE    = 32'sd65536;
	localparam w_t   W_QMAX   = 64'sd2147483647;
	localparam w_t   W_QMIN   = -64'sd2147483648;
	localparam col_t COL_LAST = 2'd3;

	typedef struct packed {
		logic force_identity;
		q_t   eye_x;
		q_t   eye_y;
		q_t   eye_z;
		q_t   target_x;
		q_t   target_y;
		q_t   target_z;
		q_t   up_hint_x;
		q_t   up_hint_y;
		q_t   up_hint_z;
	} req_t;

	typedef struct {
		logic frc;
		logic degen;
		q_t   eye [3];
		sc_t  d   [3];
		sc_t  p   [3];
	} fo_t;

	typedef struct {
		logic frc;
		logic degen;
		q_t   eye [3];
		e_t   f   [3];
		e_t   up  [3];
	} uo_t;

	typedef struct {
		logic degen;
		q_t   m [4][4];
	} mat_t;

	function automatic sh_t msb_pos(input mag_t m);
		sh_t p;
		p = '0;
		for (int i = 0; i < MW; i++) begin
			if (m[i]) p = SHW'(i);
		end
		return p;
	endfunction

	function automatic sc_t scale(input mag_t m, input logic neg, input sh_t p);
		mag_t          t;
		logic [SW-2:0] r;
		if (p < SHW'(SCALE_MSB)) t = m << (SHW'(SCALE_MSB) - p);
		else t = m >> (p - SHW'(SCALE_MSB));
		r = t[SW-2:0];
		return neg ? -sc_t'({1'b0, r}) : sc_t'({1'b0, r});
	endfunction

	function automatic mag_t pmag(input pr_t v);
		pr_t a;
		a = v[2*SW-1] ? -v : v;
		return a[MW-1:0];
	endfunction

	function automatic mag_t mag33(input logic signed [QW:0] v);
		logic signed [QW:0] a;
		a = v[QW] ? -v : v;
		return MW'(unsigned'(a));
	endfunction

	function automatic w_t round16(input w_t v);
		logic [DDW-1:0] m;
		m = v[DDW-1] ? DDW'(-v) : DDW'(v);
		m = (m + (DDW'(1) << (FRAC - 1))) >> FRAC;
		return v[DDW-1] ? -w_t'(m) : w_t'(m);
	endfunction

	function automatic q_t sat32(input w_t v);
		if (v > W_QMAX) return QW'(W_QMAX);
		if (v < W_QMIN) return QW'(W_QMIN);
		return QW'(v);
	endfunction

endpackage

@@ rtl/lav_front.sv @@
// Front pipeline: view direction, block scaling and the two orthogonalizing cross products.
module lav_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          in_valid,
	input  lav_pkg::req_t in_item,
	output logic          out_valid,
	output lav_pkg::fo_t  out_item
);
	import lav_pkg::*;

	localparam int NS = 11;

	typedef struct {
		logic frc;
		logic degen;
		q_t   eye [3];
		mag_t mag [2][3];
		logic neg [2][3];
		sh_t  sh  [2];
		sc_t  d   [3];
		sc_t  w   [3];
		pr_t  pr  [6];
	} fr_t;

	fr_t           pipe_s [NS];
	fr_t           nx     [NS];
	logic [NS-1:0] vld_s;

	always_comb begin
		logic signed [QW:0] dv [3];
		q_t                 tg [3];
		q_t                 uh [3];
		pr_t                cv [3];

		nx[0] = '{default: '0};
		nx[0].frc = in_item.force_identity;
		nx[0].eye[0] = in_item.eye_x;
		nx[0].eye[1] = in_item.eye_y;
		nx[0].eye[2] = in_item.eye_z;
		tg[0] = in_item.target_x;
		tg[1] = in_item.target_y;
		tg[2] = in_item.target_z;
		uh[0] = in_item.up_hint_x;
		uh[1] = in_item.up_hint_y;
		uh[2] = in_item.up_hint_z;
		for (int i = 0; i < 3; i++) begin
			dv[i] = (QW+1)'(tg[i]) - (QW+1)'(nx[0].eye[i]);
			nx[0].mag[0][i] = mag33(dv[i]);
			nx[0].neg[0][i] = dv[i][QW];
			nx[0].mag[1][i] = mag33((QW+1)'(uh[i]));
			nx[0].neg[1][i] = uh[i][QW-1];
		end
		nx[0].degen = !in_item.force_identity && dv[0] == '0 && dv[1] == '0 && dv[2] == '0;

		// leading one of both vectors
		nx[1] = pipe_s[0];
		for (int j = 0; j < 2; j++) begin
			nx[1].sh[j] = msb_pos(pipe_s[0].mag[j][0] | pipe_s[0].mag[j][1] | pipe_s[0].mag[j][2]);
		end

		nx[2] = pipe_s[1];
		for (int i = 0; i < 3; i++) begin
			nx[2].d[i] = scale(pipe_s[1].mag[0][i], pipe_s[1].neg[0][i], pipe_s[1].sh[0]);
			nx[2].w[i] = scale(pipe_s[1].mag[1][i], pipe_s[1].neg[1][i], pipe_s[1].sh[1]);
		end

		// right = up x dir
		nx[3] = pipe_s[2];
		nx[3].pr[0] = pipe_s[2].w[1] * pipe_s[2].d[2];
		nx[3].pr[1] = pipe_s[2].w[2] * pipe_s[2].d[1];
		nx[3].pr[2] = pipe_s[2].w[2] * pipe_s[2].d[0];
		nx[3].pr[3] = pipe_s[2].w[0] * pipe_s[2].d[2];
		nx[3].pr[4] = pipe_s[2].w[0] * pipe_s[2].d[1];
		nx[3].pr[5] = pipe_s[2].w[1] * pipe_s[2].d[0];

		nx[4] = pipe_s[3];
		for (int i = 0; i < 3; i++) begin
			cv[i] = pipe_s[3].pr[2*i] - pipe_s[3].pr[2*i+1];
			nx[4].mag[0][i] = pmag(cv[i]);
			nx[4].neg[0][i] = cv[i][2*SW-1];
		end
		nx[4].degen = pipe_s[3].degen
			|| (!pipe_s[3].frc && cv[0] == '0 && cv[1] == '0 && cv[2] == '0);

		nx[5] = pipe_s[4];
		nx[5].sh[0] = msb_pos(pipe_s[4].mag[0][0] | pipe_s[4].mag[0][1] | pipe_s[4].mag[0][2]);

		nx[6] = pipe_s[5];
		for (int i = 0; i < 3; i++) begin
			nx[6].w[i] = scale(pipe_s[5].mag[0][i], pipe_s[5].neg[0][i], pipe_s[5].sh[0]);
		end

		// up' = dir x right
		nx[7] = pipe_s[6];
		nx[7].pr[0] = pipe_s[6].d[1] * pipe_s[6].w[2];
		nx[7].pr[1] = pipe_s[6].d[2] * pipe_s[6].w[1];
		nx[7].pr[2] = pipe_s[6].d[2] * pipe_s[6].w[0];
		nx[7].pr[3] = pipe_s[6].d[0] * pipe_s[6].w[2];
		nx[7].pr[4] = pipe_s[6].d[0] * pipe_s[6].w[1];
		nx[7].pr[5] = pipe_s[6].d[1] * pipe_s[6].w[0];

		nx[8] = pipe_s[7];
		for (int i = 0; i < 3; i++) begin
			cv[i] = pipe_s[7].pr[2*i] - pipe_s[7].pr[2*i+1];
			nx[8].mag[0][i] = pmag(cv[i]);
			nx[8].neg[0][i] = cv[i][2*SW-1];
		end
		nx[8].degen = pipe_s[7].degen
			|| (!pipe_s[7].frc && cv[0] == '0 && cv[1] == '0 && cv[2] == '0);

		nx[9] = pipe_s[8];
		nx[9].sh[0] = msb_pos(pipe_s[8].mag[0][0] | pipe_s[8].mag[0][1] | pipe_s[8].mag[0][2]);

		nx[10] = pipe_s[9];
		for (int i = 0; i < 3; i++) begin
			nx[10].w[i] = scale(pipe_s[9].mag[0][i], pipe_s[9].neg[0][i], pipe_s[9].sh[0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NS-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NS; k++) pipe_s[k] <= nx[k];
		end
	end

	always_comb begin
		out_valid      = vld_s[NS-1];
		out_item.frc   = pipe_s[NS-1].frc;
		out_item.degen = pipe_s[NS-1].degen;
		for (int i = 0; i < 3; i++) begin
			out_item.eye[i] = pipe_s[NS-1].eye[i];
			out_item.d[i]   = pipe_s[NS-1].d[i];
			out_item.p[i]   = pipe_s[NS-1].w[i];
		end
	end

endmodule

@@ rtl/lav_unit.sv @@
// Normalization pipeline: sum of squares, bit-per-stage square root and restoring division.
module lav_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         adv,
	input  logic         in_valid,
	input  lav_pkg::fo_t in_item,
	output logic         out_valid,
	output lav_pkg::uo_t out_item
);
	import lav_pkg::*;

	localparam int RT0 = 2;
	localparam int NUM = RT0 + RT_STEPS;
	localparam int DV0 = NUM + 1;
	localparam int NS  = DV0 + DV_STEPS;

	typedef struct {
		logic                frc;
		logic                degen;
		q_t                  eye  [3];
		logic [SW-2:0]       mag  [2][3];
		logic                neg  [2][3];
		logic [2*SW-3:0]     sq   [2][3];
		logic [DDW-1:0]      rem  [2];
		logic [SW-1:0]       root [2];
		logic [NW-1:0]       num  [2][3];
		logic [DV_STEPS-1:0] q    [2][3];
	} un_t;

	un_t           pipe_s [NS];
	un_t           nx     [NS];
	logic [NS-1:0] vld_s;

	always_comb begin
		sc_t            a;
		logic [DDW-1:0] trial;
		logic [NW-1:0]  dsr;
		int             bi;

		nx[0] = '{default: '0};
		nx[0].frc   = in_item.frc;
		nx[0].degen = in_item.degen;
		for (int i = 0; i < 3; i++) begin
			nx[0].eye[i] = in_item.eye[i];
			a = in_item.d[i][SW-1] ? -in_item.d[i] : in_item.d[i];
			nx[0].mag[0][i] = a[SW-2:0];
			nx[0].neg[0][i] = in_item.d[i][SW-1];
			a = in_item.p[i][SW-1] ? -in_item.p[i] : in_item.p[i];
			nx[0].mag[1][i] = a[SW-2:0];
			nx[0].neg[1][i] = in_item.p[i][SW-1];
			nx[0].sq[0][i] = nx[0].mag[0][i] * nx[0].mag[0][i];
			nx[0].sq[1][i] = nx[0].mag[1][i] * nx[0].mag[1][i];
		end

		nx[1] = pipe_s[0];
		for (int v = 0; v < 2; v++) begin
			nx[1].rem[v]  = DDW'(pipe_s[0].sq[v][0]) + DDW'(pipe_s[0].sq[v][1])
				+ DDW'(pipe_s[0].sq[v][2]);
			nx[1].root[v] = '0;
		end

		// one root bit per stage, most significant first
		for (int k = RT0; k < NUM; k++) begin
			bi = NUM - 1 - k;
			nx[k] = pipe_s[k-1];
			for (int v = 0; v < 2; v++) begin
				trial = (DDW'(pipe_s[k-1].root[v]) << (bi + 1)) + (DDW'(1) << (2 * bi));
				if (pipe_s[k-1].rem[v] >= trial) begin
					nx[k].rem[v]      = pipe_s[k-1].rem[v] - trial;
					nx[k].root[v][bi] = 1'b1;
				end
			end
		end

		nx[NUM] = pipe_s[NUM-1];
		for (int v = 0; v < 2; v++) begin
			for (int i = 0; i < 3; i++) begin
				nx[NUM].num[v][i] = (NW'(pipe_s[NUM-1].mag[v][i]) << FRAC)
					+ NW'(pipe_s[NUM-1].root[v] >> 1);
				nx[NUM].q[v][i]   = '0;
			end
		end

		// one quotient bit per stage
		for (int k = DV0; k < NS; k++) begin
			bi = NS - 1 - k;
			nx[k] = pipe_s[k-1];
			for (int v = 0; v < 2; v++) begin
				dsr = NW'(pipe_s[k-1].root[v]) << bi;
				for (int i = 0; i < 3; i++) begin
					if (pipe_s[k-1].num[v][i] >= dsr) begin
						nx[k].num[v][i]     = pipe_s[k-1].num[v][i] - dsr;
						nx[k].q[v][i][bi]   = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NS-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NS; k++) pipe_s[k] <= nx[k];
		end
	end

	always_comb begin
		out_valid      = vld_s[NS-1];
		out_item.frc   = pipe_s[NS-1].frc;
		out_item.degen = pipe_s[NS-1].degen;
		for (int i = 0; i < 3; i++) begin
			out_item.eye[i] = pipe_s[NS-1].eye[i];
			out_item.f[i]   = pipe_s[NS-1].neg[0][i] ? -e_t'({1'b0, pipe_s[NS-1].q[0][i]})
				: e_t'({1'b0, pipe_s[NS-1].q[0][i]});
			out_item.up[i]  = pipe_s[NS-1].neg[1][i] ? -e_t'({1'b0, pipe_s[NS-1].q[1][i]})
				: e_t'({1'b0, pipe_s[NS-1].q[1][i]});
		end
	end

endmodule

@@ rtl/lav_back.sv @@
// Back pipeline: side and true up vectors, translation dot products and matrix assembly.
module lav_back (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         adv,
	input  logic         in_valid,
	input  lav_pkg::uo_t in_item,
	output logic         out_valid,
	output lav_pkg::mat_t out_item
);
	import lav_pkg::*;

	localparam int NS = 6;

	typedef struct {
		logic frc;
		logic degen;
		q_t   eye [3];
		e_t   f   [3];
		e_t   up  [3];
		e_t   s   [3];
		e_t   u   [3];
		ep_t  pr  [6];
		dp_t  dp  [3][3];
		q_t   t   [3];
	} bk_t;

	bk_t           pipe_s [NS];
	bk_t           nx     [NS];
	logic [NS-1:0] vld_s;

	always_comb begin
		w_t dot;
		e_t nf;

		nx[0] = '{default: '0};
		nx[0].frc   = in_item.frc;
		nx[0].degen = in_item.degen;
		for (int i = 0; i < 3; i++) begin
			nx[0].eye[i] = in_item.eye[i];
			nx[0].f[i]   = in_item.f[i];
			nx[0].up[i]  = in_item.up[i];
		end
		// side = f x up
		nx[0].pr[0] = in_item.f[1] * in_item.up[2];
		nx[0].pr[1] = in_item.f[2] * in_item.up[1];
		nx[0].pr[2] = in_item.f[2] * in_item.up[0];
		nx[0].pr[3] = in_item.f[0] * in_item.up[2];
		nx[0].pr[4] = in_item.f[0] * in_item.up[1];
		nx[0].pr[5] = in_item.f[1] * in_item.up[0];

		nx[1] = pipe_s[0];
		for (int i = 0; i < 3; i++) begin
			nx[1].s[i] = EW'(round16(w_t'(pipe_s[0].pr[2*i]) - w_t'(pipe_s[0].pr[2*i+1])));
		end

		// true up = side x f
		nx[2] = pipe_s[1];
		nx[2].pr[0] = pipe_s[1].s[1] * pipe_s[1].f[2];
		nx[2].pr[1] = pipe_s[1].s[2] * pipe_s[1].f[1];
		nx[2].pr[2] = pipe_s[1].s[2] * pipe_s[1].f[0];
		nx[2].pr[3] = pipe_s[1].s[0] * pipe_s[1].f[2];
		nx[2].pr[4] = pipe_s[1].s[0] * pipe_s[1].f[1];
		nx[2].pr[5] = pipe_s[1].s[1] * pipe_s[1].f[0];

		nx[3] = pipe_s[2];
		for (int i = 0; i < 3; i++) begin
			nx[3].u[i] = EW'(round16(w_t'(pipe_s[2].pr[2*i]) - w_t'(pipe_s[2].pr[2*i+1])));
		end

		nx[4] = pipe_s[3];
		for (int c = 0; c < 3; c++) begin
			nf = -pipe_s[3].f[c];
			nx[4].dp[0][c] = pipe_s[3].s[c] * pipe_s[3].eye[c];
			nx[4].dp[1][c] = pipe_s[3].u[c] * pipe_s[3].eye[c];
			nx[4].dp[2][c] = nf * pipe_s[3].eye[c];
		end

		nx[5] = pipe_s[4];
		for (int r = 0; r < 3; r++) begin
			dot = w_t'(pipe_s[4].dp[r][0]) + w_t'(pipe_s[4].dp[r][1])
				+ w_t'(pipe_s[4].dp[r][2]);
			nx[5].t[r] = sat32(-round16(dot));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NS-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NS; k++) pipe_s[k] <= nx[k];
		end
	end

	always_comb begin
		out_valid      = vld_s[NS-1];
		out_item.degen = pipe_s[NS-1].degen;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				out_item.m[r][c] = (r == c) ? Q_ONE : '0;
			end
		end
		if (!pipe_s[NS-1].frc && !pipe_s[NS-1].degen) begin
			for (int c = 0; c < 3; c++) begin
				out_item.m[0][c] = QW'(pipe_s[NS-1].s[c]);
				out_item.m[1][c] = QW'(pipe_s[NS-1].u[c]);
				out_item.m[2][c] = QW'(-pipe_s[NS-1].f[c]);
				out_item.m[c][3] = pipe_s[NS-1].t[c];
			end
		end
	end

endmodule

@@ rtl/lav_colser.sv @@
// Result register: holds one finished matrix and hands it out a column per transaction.
module lav_colser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load_valid,
	input  lav_pkg::mat_t load_item,
	output logic          can_load,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output lav_pkg::col_t column_index,
	output lav_pkg::q_t   entry_row0,
	output lav_pkg::q_t   entry_row1,
	output lav_pkg::q_t   entry_row2,
	output lav_pkg::q_t   entry_row3,
	output logic          last_column,
	output logic          degenerate
);
	import lav_pkg::*;

	logic busy_q;
	col_t col_q;
	mat_t mat_q;

	assign can_load = !busy_q || (rsp_ready && col_q == COL_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			col_q  <= '0;
		end else if (can_load) begin
			busy_q <= load_valid;
			col_q  <= '0;
		end else if (rsp_ready) begin
			col_q <= col_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load_valid) mat_q <= load_item;
	end

	assign rsp_valid    = busy_q;
	assign column_index = col_q;
	assign entry_row0   = mat_q.m[0][col_q];
	assign entry_row1   = mat_q.m[1][col_q];
	assign entry_row2   = mat_q.m[2][col_q];
	assign entry_row3   = mat_q.m[3][col_q];
	assign last_column  = (col_q == COL_LAST);
	assign degenerate   = mat_q.degen;

endmodule

@@ rtl/look_at_view_matrix.sv @@
// Top level of the look-at view matrix block.
// A request runs through the pipeline into the result register; its columns then leave
// one a cycle while rsp_ready is high, and the four columns bound the request rate;
// the 69-stage pipeline takes a request every cycle while its last stage can drain.
// Reset: arst_n clears all valid bits and the column counter; data registers keep no reset.
module look_at_view_matrix (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic        force_identity,
	input  lav_pkg::q_t eye_x,
	input  lav_pkg::q_t eye_y,
	input  lav_pkg::q_t eye_z,
	input  lav_pkg::q_t target_x,
	input  lav_pkg::q_t target_y,
	input  lav_pkg::q_t target_z,
	input  lav_pkg::q_t up_hint_x,
	input  lav_pkg::q_t up_hint_y,
	input  lav_pkg::q_t up_hint_z,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [1:0]  column_index,
	output lav_pkg::q_t entry_row0,
	output lav_pkg::q_t entry_row1,
	output lav_pkg::q_t entry_row2,
	output lav_pkg::q_t entry_row3,
	output logic        last_column,
	output logic        degenerate
);
	import lav_pkg::*;

	req_t req;
	fo_t  fr_item;
	uo_t  un_item;
	mat_t bk_item;
	logic fr_valid;
	logic un_valid;
	logic bk_valid;
	logic can_load;
	logic adv;

	assign adv       = !bk_valid || can_load;
	assign req_ready = adv;

	assign req = '{
		force_identity: force_identity,
		eye_x: eye_x, eye_y: eye_y, eye_z: eye_z,
		target_x: target_x, target_y: target_y, target_z: target_z,
		up_hint_x: up_hint_x, up_hint_y: up_hint_y, up_hint_z: up_hint_z
	};

	lav_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (req_valid),
		.in_item   (req),
		.out_valid (fr_valid),
		.out_item  (fr_item)
	);

	lav_unit u_unit (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (fr_valid),
		.in_item   (fr_item),
		.out_valid (un_valid),
		.out_item  (un_item)
	);

	lav_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (un_valid),
		.in_item   (un_item),
		.out_valid (bk_valid),
		.out_item  (bk_item)
	);

	lav_colser u_colser (
		.clk          (clk),
		.arst_n       (arst_n),
		.load_valid   (bk_valid),
		.load_item    (bk_item),
		.can_load     (can_load),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.column_index (column_index),
		.entry_row0   (entry_row0),
		.entry_row1   (entry_row1),
		.entry_row2   (entry_row2),
		.entry_row3   (entry_row3),
		.last_column  (last_column),
		.degenerate   (degenerate)
	);

endmodule

@@ rtl/lav_checker.sv @@
// Port-level checks for the look-at view matrix block, bound to the top level.
module lav_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        force_identity,
	input lav_pkg::q_t eye_x,
	input lav_pkg::q_t eye_y,
	input lav_pkg::q_t eye_z,
	input lav_pkg::q_t target_x,
	input lav_pkg::q_t target_y,
	input lav_pkg::q_t target_z,
	input lav_pkg::q_t up_hint_x,
	input lav_pkg::q_t up_hint_y,
	input lav_pkg::q_t up_hint_z,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  column_index,
	input lav_pkg::q_t entry_row0,
	input lav_pkg::q_t entry_row1,
	input lav_pkg::q_t entry_row2,
	input lav_pkg::q_t entry_row3,
	input logic        last_column,
	input logic        degenerate
);
	import lav_pkg::*;

	// columns of one matrix follow each other without a gap
	a_col_next: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !last_column
		|=> rsp_valid && column_index == $past(column_index) + 2'd1)
		else $error("column sequence broken");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> last_column == (column_index == COL_LAST))
		else $error("last_column does not match column_index");

	a_degen_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && !last_column |=> $stable(degenerate))
		else $error("degenerate changed within a matrix");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready
		|=> rsp_valid && $stable(column_index) && $stable(entry_row0))
		else $error("stalled transaction changed");

	a_degen_ident: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && degenerate
		|-> entry_row0 == ((column_index == 2'd0) ? Q_ONE : '0))
		else $error("degenerate matrix is not the identity");

endmodule

bind look_at_view_matrix lav_checker u_lav_checker (.*);
